FILE: hw/rtl/lbcbp_pkg.sv
// shared types, constants and helpers for the linked block channel buffer pool
`timescale 1ns / 1ps
package lbcbp_pkg;

    localparam int BLOCK_SIZE   = 256;
    localparam int NUM_BLOCKS   = 8;
    localparam int NUM_CHANNELS = 4;

    localparam int ADDR_W     = 11;
    localparam int CNT_W      = 11;
    localparam int CH_W       = 2;
    localparam int CH_SLOTS   = 4;
    localparam int POOL_BYTES = NUM_BLOCKS * BLOCK_SIZE;
    localparam int POOL_AW    = $clog2(POOL_BYTES);
    localparam int OFS_W      = $clog2(BLOCK_SIZE);

    localparam logic [7:0]       NO_LINK     = 8'hFF;
    localparam logic [CNT_W-1:0] LIMIT_RESET = 11'd2040;
    localparam logic [OFS_W-1:0] LAST_OFS    = OFS_W'(BLOCK_SIZE - 1);

    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_LIMIT  = 3'd1,
        ST_NOBLK  = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_BROKEN = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LINK,
        S_PUT,
        S_LINKRD,
        S_DATARD
    } back_state_t;

    typedef struct packed {
        logic            op;
        logic [CH_W-1:0] channel;
        logic [7:0]      data;
        logic            chan_ok;
    } item_t;

    typedef struct packed {
        logic            found;
        logic [7:0]      idx;
    } grab_t;

    // lowest free block
    function automatic grab_t lowest_free(input logic [NUM_BLOCKS-1:0] map);
        grab_t g;
        g.found = 1'b0;
        g.idx   = NO_LINK;
        for (int j = NUM_BLOCKS - 1; j >= 0; j--) begin
            if (map[j]) begin
                g.found = 1'b1;
                g.idx   = 8'(j);
            end
        end
        return g;
    endfunction

    // first byte address of a block
    function automatic logic [ADDR_W-1:0] blk_base(input logic [7:0] b);
        return ADDR_W'({{(ADDR_W){1'b0}}, b} << OFS_W);
    endfunction

    // block number holding an address
    function automatic logic [7:0] blk_of(input logic [ADDR_W-1:0] a);
        return 8'(a >> OFS_W);
    endfunction

    // mark a block free, ignoring numbers beyond the pool
    function automatic logic [NUM_BLOCKS-1:0] drop_blk(input logic [NUM_BLOCKS-1:0] map,
                                                       input logic [7:0] b);
        logic [NUM_BLOCKS-1:0] m;
        m = map;
        for (int j = 0; j < NUM_BLOCKS; j++) begin
            if (b == 8'(j)) begin
                m[j] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

FILE: hw/rtl/lbcbp_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module lbcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/lbcbp_front.sv
// front end: takes words, classifies them and queues them for the back end
`timescale 1ns / 1ps
module lbcbp_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_op,
    input  logic [lbcbp_pkg::CH_W-1:0] s_channel,
    input  logic [7:0]               s_data_in,
    output logic                     q_valid,
    output lbcbp_pkg::item_t         q_item,
    input  logic                     q_pop
);

    lbcbp_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    lbcbp_pkg::item_t in_item;

    // classify the incoming word
    always_comb begin
        in_item.op      = s_op;
        in_item.channel = s_channel;
        in_item.data    = s_data_in;
        in_item.chan_ok = (32'(s_channel) < lbcbp_pkg::NUM_CHANNELS);
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    // queue pointers
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: hw/rtl/lbcbp_back.sv
// back end: block allocation, link walking and pool access for one word at a time
`timescale 1ns / 1ps
module lbcbp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lbcbp_pkg::CNT_W-1:0]   fill_limit,
    input  logic                          q_valid,
    input  lbcbp_pkg::item_t              q_item,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_data_out,
    output logic                          m_accepted,
    output logic [2:0]                    m_status,
    output logic [lbcbp_pkg::CNT_W-1:0]   m_level
);

    localparam int AW = lbcbp_pkg::ADDR_W;
    localparam int CW = lbcbp_pkg::CNT_W;
    localparam int NB = lbcbp_pkg::NUM_BLOCKS;
    localparam int NS = lbcbp_pkg::CH_SLOTS;

    lbcbp_pkg::back_state_t state_reg, state_next;
    logic [NB-1:0] free_reg, free_next;
    logic [AW-1:0] wp_reg [NS];
    logic [AW-1:0] wp_next [NS];
    logic [AW-1:0] rp_reg [NS];
    logic [AW-1:0] rp_next [NS];
    logic [CW-1:0] cnt_reg [NS];
    logic [CW-1:0] cnt_next [NS];
    logic [NS-1:0] holds_reg, holds_next;
    lbcbp_pkg::item_t cur_reg, cur_next;
    logic [AW-1:0] link_addr_reg, link_addr_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_data_reg, out_data_next;
    lbcbp_pkg::status_t out_status_reg, out_status_next;
    logic [CW-1:0] out_level_reg, out_level_next;

    logic                           ram_we;
    logic [lbcbp_pkg::POOL_AW-1:0]  ram_waddr, ram_raddr;
    logic [7:0]                     ram_wdata, ram_rdata;

    logic                        out_free;
    lbcbp_pkg::grab_t            g;
    logic [lbcbp_pkg::CH_W-1:0]  c;
    logic [CW-1:0]               cnt_dec;
    logic [AW-1:0]               rp_inc;

    lbcbp_ram #(
        .WIDTH(8),
        .DEPTH(lbcbp_pkg::POOL_BYTES)
    ) u_pool (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free   = !out_valid_reg || m_ready;
    assign g          = lbcbp_pkg::lowest_free(free_reg);
    assign m_valid    = out_valid_reg;
    assign m_data_out = out_data_reg;
    assign m_accepted = (out_status_reg == lbcbp_pkg::ST_OK);
    assign m_status   = out_status_reg;
    assign m_level    = out_level_reg;

    // next state, channel bookkeeping and pool accesses
    always_comb begin
        state_next      = state_reg;
        free_next       = free_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        cnt_next        = cnt_reg;
        holds_next      = holds_reg;
        cur_next        = cur_reg;
        link_addr_next  = link_addr_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_level_next  = out_level_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;
        c               = cur_reg.channel;
        cnt_dec         = cnt_reg[cur_reg.channel] - CW'(1);
        rp_inc          = rp_reg[cur_reg.channel] + AW'(1);

        case (state_reg)
            lbcbp_pkg::S_IDLE: begin
                c = q_item.channel;
                if (q_valid && out_free) begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    if (!q_item.chan_ok) begin
                        // channel without storage
                        out_valid_next  = 1'b1;
                        out_data_next   = 8'd0;
                        out_status_next = (q_item.op == lbcbp_pkg::OP_GET) ?
                                          lbcbp_pkg::ST_EMPTY : lbcbp_pkg::ST_LIMIT;
                        out_level_next  = '0;
                    end else if (q_item.op == lbcbp_pkg::OP_PUT) begin
                        if (cnt_reg[c] > fill_limit) begin
                            out_valid_next  = 1'b1;
                            out_data_next   = 8'd0;
                            out_status_next = lbcbp_pkg::ST_LIMIT;
                            out_level_next  = cnt_reg[c];
                        end else if (!holds_reg[c]) begin
                            // first block of a channel
                            if (!g.found) begin
                                cnt_next[c]     = '0;
                                out_valid_next  = 1'b1;
                                out_data_next   = 8'd0;
                                out_status_next = lbcbp_pkg::ST_NOBLK;
                                out_level_next  = '0;
                            end else begin
                                free_next     = free_reg & ~(NB'(1) << g.idx);
                                holds_next[c] = 1'b1;
                                wp_next[c]    = lbcbp_pkg::blk_base(g.idx);
                                rp_next[c]    = lbcbp_pkg::blk_base(g.idx);
                                ram_we        = 1'b1;
                                ram_waddr     = lbcbp_pkg::POOL_AW'(
                                    lbcbp_pkg::blk_base(g.idx) + AW'(lbcbp_pkg::BLOCK_SIZE - 1));
                                ram_wdata     = lbcbp_pkg::NO_LINK;
                                state_next    = lbcbp_pkg::S_PUT;
                            end
                        end else if (wp_reg[c][lbcbp_pkg::OFS_W-1:0] == lbcbp_pkg::LAST_OFS)
                        begin
                            // block full: chain a new one through the link byte
                            ram_we    = 1'b1;
                            ram_waddr = lbcbp_pkg::POOL_AW'(wp_reg[c]);
                            ram_wdata = g.found ? g.idx : lbcbp_pkg::NO_LINK;
                            if (!g.found) begin
                                out_valid_next  = 1'b1;
                                out_data_next   = 8'd0;
                                out_status_next = lbcbp_pkg::ST_NOBLK;
                                out_level_next  = cnt_reg[c];
                            end else begin
                                free_next      = free_reg & ~(NB'(1) << g.idx);
                                wp_next[c]     = lbcbp_pkg::blk_base(g.idx);
                                link_addr_next = lbcbp_pkg::blk_base(g.idx) +
                                                 AW'(lbcbp_pkg::BLOCK_SIZE - 1);
                                state_next     = lbcbp_pkg::S_LINK;
                            end
                        end else begin
                            // plain store
                            ram_we          = 1'b1;
                            ram_waddr       = lbcbp_pkg::POOL_AW'(wp_reg[c]);
                            ram_wdata       = q_item.data;
                            wp_next[c]      = wp_reg[c] + AW'(1);
                            cnt_next[c]     = cnt_reg[c] + CW'(1);
                            out_valid_next  = 1'b1;
                            out_data_next   = 8'd0;
                            out_status_next = lbcbp_pkg::ST_OK;
                            out_level_next  = cnt_reg[c] + CW'(1);
                        end
                    end else begin
                        if (cnt_reg[c] == '0) begin
                            holds_next[c]   = 1'b0;
                            out_valid_next  = 1'b1;
                            out_data_next   = 8'd0;
                            out_status_next = lbcbp_pkg::ST_EMPTY;
                            out_level_next  = '0;
                        end else if (rp_reg[c][lbcbp_pkg::OFS_W-1:0] == lbcbp_pkg::LAST_OFS)
                        begin
                            // drained block: free it and fetch its link
                            free_next  = lbcbp_pkg::drop_blk(free_reg,
                                                             lbcbp_pkg::blk_of(rp_reg[c]));
                            ram_raddr  = lbcbp_pkg::POOL_AW'(rp_reg[c]);
                            state_next = lbcbp_pkg::S_LINKRD;
                        end else begin
                            ram_raddr  = lbcbp_pkg::POOL_AW'(rp_reg[c]);
                            state_next = lbcbp_pkg::S_DATARD;
                        end
                    end
                end
            end
            lbcbp_pkg::S_LINK: begin
                // mark the new block's link as none
                ram_we     = 1'b1;
                ram_waddr  = lbcbp_pkg::POOL_AW'(link_addr_reg);
                ram_wdata  = lbcbp_pkg::NO_LINK;
                state_next = lbcbp_pkg::S_PUT;
            end
            lbcbp_pkg::S_PUT: begin
                ram_we          = 1'b1;
                ram_waddr       = lbcbp_pkg::POOL_AW'(wp_reg[c]);
                ram_wdata       = cur_reg.data;
                wp_next[c]      = wp_reg[c] + AW'(1);
                cnt_next[c]     = cnt_reg[c] + CW'(1);
                out_valid_next  = 1'b1;
                out_data_next   = 8'd0;
                out_status_next = lbcbp_pkg::ST_OK;
                out_level_next  = cnt_reg[c] + CW'(1);
                state_next      = lbcbp_pkg::S_IDLE;
            end
            lbcbp_pkg::S_LINKRD: begin
                if (ram_rdata >= 8'(NB)) begin
                    // broken chain resets the channel
                    holds_next[c]   = 1'b0;
                    cnt_next[c]     = '0;
                    out_valid_next  = 1'b1;
                    out_data_next   = 8'd0;
                    out_status_next = lbcbp_pkg::ST_BROKEN;
                    out_level_next  = '0;
                    state_next      = lbcbp_pkg::S_IDLE;
                end else begin
                    rp_next[c] = lbcbp_pkg::blk_base(ram_rdata);
                    ram_raddr  = lbcbp_pkg::POOL_AW'(lbcbp_pkg::blk_base(ram_rdata));
                    state_next = lbcbp_pkg::S_DATARD;
                end
            end
            lbcbp_pkg::S_DATARD: begin
                rp_next[c]  = rp_inc;
                cnt_next[c] = cnt_dec;
                if (cnt_dec == '0) begin
                    free_next     = lbcbp_pkg::drop_blk(free_reg, lbcbp_pkg::blk_of(rp_inc));
                    holds_next[c] = 1'b0;
                end
                out_valid_next  = 1'b1;
                out_data_next   = ram_rdata;
                out_status_next = lbcbp_pkg::ST_OK;
                out_level_next  = cnt_dec;
                state_next      = lbcbp_pkg::S_IDLE;
            end
            default: begin
                state_next = lbcbp_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lbcbp_pkg::S_IDLE;
            free_reg      <= '1;
            holds_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NS; i++) begin
                wp_reg[i]  <= '0;
                rp_reg[i]  <= '0;
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            holds_reg     <= holds_next;
            out_valid_reg <= out_valid_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        link_addr_reg  <= link_addr_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_level_reg  <= out_level_next;
    end

endmodule

FILE: hw/rtl/linked_block_channel_buffer_pool.sv
// top level: channel byte queues sharing a pool of linked blocks
// a put within a block is stored from idle; a put that opens a channel goes on to S_PUT, one
// that chains a block through S_LINK and S_PUT; a get reads in S_DATARD, across a link after S_LINKRD
// the back end handles one word at a time, with the single write and read port of the pool
// a two word queue between front and back absorbs stalls on either side
// reset (aresetn, synchronous, active low): all blocks free, all channels empty, limit 2040
`timescale 1ns / 1ps
module linked_block_channel_buffer_pool (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [1:0]                    s_channel,
    input  logic [7:0]                    s_data_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_data_out,
    output logic                          m_accepted,
    output logic [2:0]                    m_status,
    output logic [10:0]                   m_level,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [10:0]                   cfg_data
);

    logic [lbcbp_pkg::CNT_W-1:0] fill_limit_reg;
    logic                        q_valid;
    logic                        q_pop;
    lbcbp_pkg::item_t            q_item;

    // fill limit register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_limit_reg <= lbcbp_pkg::LIMIT_RESET;
        end else if (cfg_valid) begin
            fill_limit_reg <= cfg_data;
        end
    end

    lbcbp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_channel (s_channel),
        .s_data_in (s_data_in),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    lbcbp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fill_limit (fill_limit_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data_out (m_data_out),
        .m_accepted (m_accepted),
        .m_status   (m_status),
        .m_level    (m_level)
    );

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the linked block channel buffer pool
`timescale 1ns / 1ps
module tb_top;

    localparam int HOLD_OFF_CYCLES = 600;
    localparam int STALL_LIMIT     = 20000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int RANDOM_WORDS    = 670;
    localparam int CHAIN_PUTS      = 260;

    typedef struct {
        logic [7:0]           data;
        logic                 acc;
        lbcbp_pkg::status_t   st;
        logic [10:0]          level;
    } pool_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    logic [1:0]  s_channel;
    logic [7:0]  s_data_in;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_data_out;
    logic        m_accepted;
    logic [2:0]  m_status;
    logic [10:0] m_level;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;

    // shadow pool state
    logic [7:0]                       shadow_mem [lbcbp_pkg::POOL_BYTES];
    logic [lbcbp_pkg::NUM_BLOCKS-1:0] free_blocks;
    logic [10:0]                      wr_ptr [lbcbp_pkg::NUM_CHANNELS];
    logic [10:0]                      rd_ptr [lbcbp_pkg::NUM_CHANNELS];
    logic [10:0]                      byte_cnt [lbcbp_pkg::NUM_CHANNELS];
    bit                               owns_block [lbcbp_pkg::NUM_CHANNELS];
    logic [10:0]                      put_limit;

    pool_result_t pending_results [$];
    int  fails;
    int  words_sent;
    int  words_checked;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_off_left;
    int  stall_cnt;

    linked_block_channel_buffer_pool dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_channel  (s_channel),
        .s_data_in  (s_data_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data_out (m_data_out),
        .m_accepted (m_accepted),
        .m_status   (m_status),
        .m_level    (m_level),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // lowest free block, claimed with its link byte set to none
    function automatic logic [7:0] claim_block();
        for (int b = 0; b < lbcbp_pkg::NUM_BLOCKS; b++) begin
            if (free_blocks[b]) begin
                free_blocks[b] = 1'b0;
                shadow_mem[b * lbcbp_pkg::BLOCK_SIZE + lbcbp_pkg::BLOCK_SIZE - 1] =
                    lbcbp_pkg::NO_LINK;
                return 8'(b);
            end
        end
        return lbcbp_pkg::NO_LINK;
    endfunction

    function automatic void release_block(input int b);
        if (b < lbcbp_pkg::NUM_BLOCKS) free_blocks[b] = 1'b1;
    endfunction

    function automatic lbcbp_pkg::status_t model_put(input int c, input logic [7:0] d);
        logic [7:0] b;
        if (byte_cnt[c] > put_limit) return lbcbp_pkg::ST_LIMIT;
        if (!owns_block[c]) begin
            b = claim_block();
            if (b == lbcbp_pkg::NO_LINK) begin
                byte_cnt[c] = '0;
                return lbcbp_pkg::ST_NOBLK;
            end
            owns_block[c] = 1'b1;
            wr_ptr[c] = 11'(int'(b) * lbcbp_pkg::BLOCK_SIZE);
            rd_ptr[c] = wr_ptr[c];
        end
        // end of block: chain a fresh one through the link byte
        if (int'(wr_ptr[c]) % lbcbp_pkg::BLOCK_SIZE == lbcbp_pkg::BLOCK_SIZE - 1) begin
            b = claim_block();
            shadow_mem[wr_ptr[c]] = b;
            if (b == lbcbp_pkg::NO_LINK) return lbcbp_pkg::ST_NOBLK;
            wr_ptr[c] = 11'(int'(b) * lbcbp_pkg::BLOCK_SIZE);
        end
        shadow_mem[wr_ptr[c]] = d;
        wr_ptr[c] = wr_ptr[c] + 11'd1;
        byte_cnt[c] = byte_cnt[c] + 11'd1;
        return lbcbp_pkg::ST_OK;
    endfunction

    function automatic lbcbp_pkg::status_t model_get(input int c, output logic [7:0] d);
        logic [7:0] link;
        d = '0;
        if (byte_cnt[c] == 0) begin
            owns_block[c] = 1'b0;
            return lbcbp_pkg::ST_EMPTY;
        end
        // end of block: free it and follow the link
        if (int'(rd_ptr[c]) % lbcbp_pkg::BLOCK_SIZE == lbcbp_pkg::BLOCK_SIZE - 1) begin
            release_block(int'(rd_ptr[c]) / lbcbp_pkg::BLOCK_SIZE);
            link = shadow_mem[rd_ptr[c]];
            if (link >= lbcbp_pkg::NUM_BLOCKS) begin
                owns_block[c] = 1'b0;
                byte_cnt[c] = '0;
                return lbcbp_pkg::ST_BROKEN;
            end
            rd_ptr[c] = 11'(int'(link) * lbcbp_pkg::BLOCK_SIZE);
        end
        d = shadow_mem[rd_ptr[c]];
        rd_ptr[c] = rd_ptr[c] + 11'd1;
        byte_cnt[c] = byte_cnt[c] - 11'd1;
        if (byte_cnt[c] == 0) begin
            release_block(int'(rd_ptr[c]) / lbcbp_pkg::BLOCK_SIZE);
            owns_block[c] = 1'b0;
        end
        return lbcbp_pkg::ST_OK;
    endfunction

    function automatic pool_result_t predict_word(input logic op, input logic [1:0] ch,
                                                  input logic [7:0] d);
        pool_result_t r;
        logic [7:0] rd;
        rd = '0;
        r.level = '0;
        if (int'(ch) >= lbcbp_pkg::NUM_CHANNELS) begin
            r.st = (op == lbcbp_pkg::OP_GET) ? lbcbp_pkg::ST_EMPTY : lbcbp_pkg::ST_LIMIT;
        end else begin
            r.st = (op == lbcbp_pkg::OP_GET) ? model_get(ch, rd) : model_put(ch, d);
            r.level = byte_cnt[ch];
        end
        r.acc  = (r.st == lbcbp_pkg::ST_OK);
        r.data = (op == lbcbp_pkg::OP_GET && r.st == lbcbp_pkg::ST_OK) ? rd : 8'h00;
        return r;
    endfunction

    // send one word, sometimes with a random gap before it
    task automatic push_word(input logic op, input logic [1:0] ch, input logic [7:0] d);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(4, 1);
            @(negedge aclk) s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid   = 1'b1;
        s_op      = op;
        s_channel = ch;
        s_data_in = d;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_word(op, ch, d));
        words_sent++;
    endtask

    // wait for all results, then write the limit register
    task automatic write_limit(input logic [10:0] value);
        @(negedge aclk) s_valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        put_limit = value;
        @(negedge aclk) cfg_valid = 1'b0;
    endtask

    // receiver: random stalls and a counted hold-off
    always @(negedge aclk) begin
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        pool_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word data %h status %0d", $time,
                         m_data_out, m_status);
                fails++;
            end else begin
                e = pending_results.pop_front();
                words_checked++;
                if (m_data_out !== e.data || m_accepted !== e.acc ||
                    m_status !== e.st || m_level !== e.level) begin
                    $display("%0t: mismatch exp data %h acc %0d st %0d lvl %0d", $time,
                             e.data, e.acc, e.st, e.level);
                    $display("%0t:          act data %h acc %0d st %0d lvl %0d", $time,
                             m_data_out, m_accepted, m_status, m_level);
                    fails++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cnt = 0;
        end else if (aresetn) begin
            stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding", $time,
                         pending_results.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // field extremes, both operations, empty get
    task automatic test_directed();
        push_word(lbcbp_pkg::OP_PUT, 2'd0, 8'h00);
        push_word(lbcbp_pkg::OP_PUT, 2'd0, 8'hFF);
        push_word(lbcbp_pkg::OP_PUT, 2'd3, 8'hA5);
        push_word(lbcbp_pkg::OP_PUT, 2'd3, 8'h5A);
        push_word(lbcbp_pkg::OP_GET, 2'd0, 8'hFF);
        push_word(lbcbp_pkg::OP_GET, 2'd0, 8'h00);
        push_word(lbcbp_pkg::OP_GET, 2'd0, 8'h00);
        push_word(lbcbp_pkg::OP_GET, 2'd1, 8'h00);
        push_word(lbcbp_pkg::OP_PUT, 2'd1, 8'h81);
        push_word(lbcbp_pkg::OP_PUT, 2'd2, 8'h7E);
        push_word(lbcbp_pkg::OP_GET, 2'd3, 8'h00);
        push_word(lbcbp_pkg::OP_GET, 2'd3, 8'h00);
        push_word(lbcbp_pkg::OP_GET, 2'd3, 8'h00);
        push_word(lbcbp_pkg::OP_GET, 2'd2, 8'h00);
        push_word(lbcbp_pkg::OP_GET, 2'd1, 8'h00);
    endtask

    // put limits 0, 3 and 2040, with over limit refusal at the lower two
    task automatic test_limits();
        logic [10:0] lims [3];
        lims = '{11'd0, 11'd3, 11'd2040};
        foreach (lims[i]) begin
            write_limit(lims[i]);
            repeat (6) push_word(lbcbp_pkg::OP_PUT, 2'd2, 8'($urandom));
            repeat (8) push_word(lbcbp_pkg::OP_GET, 2'd2, 8'h00);
        end
    endtask

    // fill one channel past a block boundary while results are held off, then drain it
    task automatic test_block_chain();
        write_limit(11'd2040);
        hold_off_left = HOLD_OFF_CYCLES;
        repeat (CHAIN_PUTS) push_word(lbcbp_pkg::OP_PUT, 2'd0, 8'($urandom));
        repeat (CHAIN_PUTS + 2) push_word(lbcbp_pkg::OP_GET, 2'd0, 8'h00);
    endtask

    // random traffic in bursts with a drifting put share
    task automatic test_random(input int words);
        int put_pct;
        int ch;
        for (int i = 0; i < words; i++) begin
            if (i % 100 == 0) put_pct = $urandom_range(80, 30);
            ch = ($urandom_range(99) < 40) ? 0 : $urandom_range(3);
            push_word(($urandom_range(99) < put_pct) ? lbcbp_pkg::OP_PUT : lbcbp_pkg::OP_GET,
                      2'(ch), 8'($urandom));
        end
    endtask

    task automatic test_random_phases();
        int per = RANDOM_WORDS / 3;
        send_idle_pct = 18;
        recv_idle_pct = 55;
        write_limit(11'($urandom_range(2040)));
        test_random(per);
        send_idle_pct = 55;
        recv_idle_pct = 18;
        write_limit(11'd300);
        test_random(per);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(11'd2040);
        test_random(RANDOM_WORDS - 2 * per);
    endtask

    initial begin
        fails         = 0;
        words_sent    = 0;
        words_checked = 0;
        stall_cnt     = 0;
        hold_off_left = 0;
        send_idle_pct = 18;
        recv_idle_pct = 55;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_op      = lbcbp_pkg::OP_PUT;
        s_channel = '0;
        s_data_in = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        // shadow reset state
        foreach (shadow_mem[i]) shadow_mem[i] = '0;
        free_blocks = '1;
        for (int c = 0; c < lbcbp_pkg::NUM_CHANNELS; c++) begin
            wr_ptr[c]     = '0;
            rd_ptr[c]     = '0;
            byte_cnt[c]   = '0;
            owns_block[c] = 1'b0;
        end
        put_limit = lbcbp_pkg::LIMIT_RESET;
        repeat (10) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;

        test_directed();
        test_limits();
        test_block_chain();
        test_random_phases();

        @(negedge aclk) s_valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered puts and gets on all channels, limits 0 to 2040, block chaining");
        $display("%0d words sent, %0d results checked, %0d failures", words_sent,
                 words_checked, fails);
        if (fails == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/lbcbp_pkg.sv
hw/rtl/lbcbp_ram.sv
hw/rtl/lbcbp_front.sv
hw/rtl/lbcbp_back.sv
hw/rtl/linked_block_channel_buffer_pool.sv
dv/tb_top.sv
